FILE: design/refcounted_block_buffer_table_macros.svh
// Assertion macros used by the buffer table checker
`ifndef REFCOUNTED_BLOCK_BUFFER_TABLE_MACROS_SVH
`define REFCOUNTED_BLOCK_BUFFER_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RBT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("buffer table check failed");

// Next-cycle implication, disabled during reset
`define RBT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("buffer table check failed");

`endif

FILE: design/rbt_pkg.sv
// Types, constants and helpers for the buffer table
`timescale 1ns / 1ps

package rbt_pkg;

   localparam int SLOTS      = 32;
   localparam int SLOT_IDX_W = $clog2(SLOTS);
   localparam int SLOT_W     = 5;
   localparam int DEV_W      = 8;
   localparam int BLK_W      = 32;
   localparam int CNT_W      = 8;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Operation codes
   localparam logic [1:0] FUNC_GET     = 2'd0;
   localparam logic [1:0] FUNC_RELEASE = 2'd1;
   localparam logic [1:0] FUNC_PIN     = 2'd2;
   localparam logic [1:0] FUNC_UNPIN   = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFREE = 2'd1;
   localparam logic [1:0] ST_UNDER  = 2'd2;
   localparam logic [1:0] ST_OVER   = 2'd3;

   typedef struct packed {
      logic [1:0]       func;
      logic [DEV_W-1:0] dev;
      logic [BLK_W-1:0] block_no;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_out;
      logic              hit;
      logic              needs_read;
      logic [1:0]        status;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic compare;
      logic pick;
      logic exec;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic new_is_get;
   } dp_stat_type;

   typedef struct packed {
      logic                  found;
      logic [SLOT_IDX_W-1:0] idx;
   } pick_type;

   // Lowest set bit of a slot vector
   function automatic pick_type first_set(input logic [SLOTS-1:0] vec);
      pick_type res;
      res = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            res.found = 1'b1;
            res.idx   = SLOT_IDX_W'(i);
         end
      end
      return res;
   endfunction

endpackage

FILE: design/refcounted_block_buffer_table.sv
// A get passes through compare, pick and execute before rsp_valid rises; release,
// pin and unpin go straight to execute. A new request is accepted only after the
// previous one has executed; execute waits while the result register still holds
// a beat that has not been taken.
// Reset clears all reference counts and the assigned and loaded flags at once.
`timescale 1ns / 1ps

module refcounted_block_buffer_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rbt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rbt_pkg::rsp_type rsp_data
);
   import rbt_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   rbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rbt_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

FILE: design/rbt_datapath.sv
// Descriptor storage, tag compare, slot pick and count update
`timescale 1ns / 1ps

module rbt_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  rbt_pkg::dp_cmd_type  cmd,
   input  rbt_pkg::req_type     req_data,
   output rbt_pkg::dp_stat_type stat,
   output rbt_pkg::rsp_type     rsp_data
);
   import rbt_pkg::*;

   req_type               req_ff;
   logic [DEV_W-1:0]      tag_dev_ff   [SLOTS];
   logic [BLK_W-1:0]      tag_block_ff [SLOTS];
   logic [CNT_W-1:0]      count_ff     [SLOTS];
   logic [SLOTS-1:0]      assigned_ff;
   logic [SLOTS-1:0]      loaded_ff;
   logic [SLOTS-1:0]      match_in, match_ff;
   logic [SLOTS-1:0]      free_in, free_ff;
   pick_type              hit_pick_in, hit_pick_ff;
   pick_type              free_pick_in, free_pick_ff;
   rsp_type               rsp_in, rsp_ff;

   logic                  is_get;
   logic                  in_range;
   logic [SLOT_IDX_W-1:0] op_idx;
   logic [CNT_W-1:0]      cur_count;
   logic                  cur_loaded;
   logic                  count_wr;
   logic [CNT_W-1:0]      count_in;
   logic                  set_loaded;
   logic                  retag;

   assign stat.new_is_get = (req_data.func == FUNC_GET);
   assign rsp_data        = rsp_ff;

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // Compare the tag against every slot and flag free slots
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_in[i] = assigned_ff[i] && (tag_dev_ff[i] == req_ff.dev)
                       && (tag_block_ff[i] == req_ff.block_no);
         free_in[i]  = (count_ff[i] == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         match_ff <= match_in;
         free_ff  <= free_in;
      end
   end

   // Pick the lowest matching slot and the lowest free slot
   assign hit_pick_in  = first_set(match_ff);
   assign free_pick_in = first_set(free_ff);

   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         hit_pick_ff  <= hit_pick_in;
         free_pick_ff <= free_pick_in;
      end
   end

   // Select the slot that the operation works on
   assign is_get   = (req_ff.func == FUNC_GET);
   assign in_range = (32'(req_ff.slot) < 32'(SLOTS));

   always_comb begin
      if (is_get) begin
         op_idx = hit_pick_ff.found ? hit_pick_ff.idx : free_pick_ff.idx;
      end else begin
         op_idx = SLOT_IDX_W'(req_ff.slot);
      end
   end

   assign cur_count  = count_ff[op_idx];
   assign cur_loaded = loaded_ff[op_idx];

   // Decide the count update and the result beat
   always_comb begin
      rsp_in     = '0;
      count_wr   = 1'b0;
      count_in   = cur_count;
      set_loaded = 1'b0;
      retag      = 1'b0;
      case (req_ff.func)
         FUNC_GET: begin
            if (hit_pick_ff.found) begin
               rsp_in.slot_out = SLOT_W'(op_idx);
               rsp_in.hit      = 1'b1;
               if (cur_count == CNT_MAX) begin
                  rsp_in.status = ST_OVER;
               end else begin
                  count_wr          = 1'b1;
                  count_in          = cur_count + 1'b1;
                  set_loaded        = 1'b1;
                  rsp_in.needs_read = ~cur_loaded;
               end
            end else if (free_pick_ff.found) begin
               rsp_in.slot_out   = SLOT_W'(op_idx);
               rsp_in.needs_read = 1'b1;
               count_wr          = 1'b1;
               count_in          = CNT_W'(1);
               set_loaded        = 1'b1;
               retag             = 1'b1;
            end else begin
               rsp_in.status = ST_NOFREE;
            end
         end
         FUNC_PIN: begin
            rsp_in.slot_out = req_ff.slot;
            if (in_range) begin
               if (cur_count == CNT_MAX) begin
                  rsp_in.status = ST_OVER;
               end else begin
                  count_wr = 1'b1;
                  count_in = cur_count + 1'b1;
               end
            end
         end
         FUNC_RELEASE, FUNC_UNPIN: begin
            rsp_in.slot_out = req_ff.slot;
            if (in_range) begin
               if (cur_count == '0) begin
                  rsp_in.status = ST_UNDER;
               end else begin
                  count_wr = 1'b1;
                  count_in = cur_count - 1'b1;
               end
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // Write back counts and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         assigned_ff <= '0;
         loaded_ff   <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (cmd.exec) begin
         if (count_wr) begin
            count_ff[op_idx] <= count_in;
         end
         if (set_loaded) begin
            loaded_ff[op_idx] <= 1'b1;
         end
         if (retag) begin
            assigned_ff[op_idx] <= 1'b1;
         end
      end
   end

   // Retag a claimed slot
   always_ff @(posedge clock) begin
      if (cmd.exec && retag) begin
         tag_dev_ff[op_idx]   <= req_ff.dev;
         tag_block_ff[op_idx] <= req_ff.block_no;
      end
   end

   // Hold the result beat
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: design/rbt_ctrl.sv
// Sequencer and result handshake for the buffer table
`timescale 1ns / 1ps

module rbt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rbt_pkg::dp_stat_type stat,
   output rbt_pkg::dp_cmd_type  cmd
);
   import rbt_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_PICK = 2'd2;
   localparam logic [1:0] S_EXEC = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Advance through compare, pick and execute
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = stat.new_is_get ? S_CMP : S_EXEC;
            end
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = S_PICK;
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            // Wait until the result register can take a new beat
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Set on execute, drop when the beat is taken
   always_comb begin
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: design/rbt_checker.sv
// Port-level checks for the buffer table, bound to the top level
`timescale 1ns / 1ps
`include "refcounted_block_buffer_table_macros.svh"

module rbt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rbt_pkg::rsp_type rsp_data
);
   import rbt_pkg::*;

   logic req_fire;
   logic rsp_stall;
   logic nofree_beat;
   logic nofree_clean;
   logic read_beat;
   logic read_clean;

   assign req_fire     = req_valid && req_ready;
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign nofree_beat  = rsp_valid && (rsp_data.status == ST_NOFREE);
   assign nofree_clean = (rsp_data.slot_out == '0) && !rsp_data.hit && !rsp_data.needs_read;
   assign read_beat    = rsp_valid && rsp_data.needs_read;
   assign read_clean   = (rsp_data.status == ST_OK) && !rsp_data.hit;

   // One item at a time: busy right after an accept
   `RBT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ready)
   // A full table reports nothing but the status
   `RBT_ASSERT_IMPL(a_nofree_clean, clock, reset, nofree_beat, nofree_clean)
   // A disk read is only asked for on a fresh claim
   `RBT_ASSERT_IMPL(a_read_on_claim, clock, reset, read_beat, read_clean)
   // Hold a stalled result beat
   `RBT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind refcounted_block_buffer_table rbt_checker u_rbt_checker (.*);
